>>> sv/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Character codes and shared types for the delimited packet relay.
// ----------------------------------------------------------------------------
package dpr_pkg;

  // Framing characters.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Hand-over of a complete packet from the framer to the emitter.
  typedef struct packed {
    logic load;
    logic port;
  } dpr_load_t;

endpackage

>>> sv/dpr_if.sv
// ----------------------------------------------------------------------------
// dpr_in_if / dpr_out_if
// Valid/ready channels for received bytes and for relayed packet bytes.
// ----------------------------------------------------------------------------
interface dpr_in_if;
  logic       valid;
  logic       ready;
  logic       source_port;
  logic [7:0] in_byte;

  modport source (output valid, source_port, in_byte, input ready);
  modport sink   (input valid, source_port, in_byte, output ready);
endinterface

interface dpr_out_if;
  logic       valid;
  logic       ready;
  logic       out_port;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_port, out_byte, last_byte, input ready);
  modport sink   (input valid, out_port, out_byte, last_byte, output ready);
endinterface

>>> sv/delimited_packet_relay.sv
// ----------------------------------------------------------------------------
// delimited_packet_relay
// Deframes tab/newline delimited fixed-length packets from two byte streams
// and relays each complete packet on the port it arrived on.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Payload
//  in_i     in   valid/ready   source_port[0], in_byte[7:0]
//  out_o    out  valid/ready   out_port[0], out_byte[7:0], last_byte
//
//  One received byte is taken in every cycle unless the input is held back.
//  It is registered, and the framing decision for it is made from that
//  register in the next cycle. A complete packet leaves as PACKET_BYTES+1
//  items, one per cycle unless the output stalls, once its closing newline
//  has gone through the input register into the emitter's single packet
//  buffer; only a second packet closing while the first is sent stalls input.
//  Reset clears the open flags, fill counts and all handshake state at once;
//  the payload store is not cleared and no clearing pass follows reset.
//  A stall on the output side holds the current item steady.
//
module delimited_packet_relay #(
  parameter int PACKET_BYTES = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpr_in_if.sink    in_i,
  dpr_out_if.source out_o
);
  import dpr_pkg::*;

  // Handover from the framer: a complete packet and the port it belongs to.
  dpr_load_t                      load;
  logic [PACKET_BYTES-2:0][7:0]   payload;
  // The emitter can accept a packet in this cycle.
  logic                           emit_free;

  // The framer keeps per-port state and collects payload bytes.
  dpr_frame #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .free_i    (emit_free),
    .load_o    (load),
    .payload_o (payload)
  );

  // The emitter copies the packet, so the framer may start filling the
  // same port again while the packet is still being sent.
  dpr_emit #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .payload_i (payload),
    .free_o    (emit_free),
    .out_o     (out_o)
  );

endmodule

>>> sv/dpr_frame.sv
// ----------------------------------------------------------------------------
// dpr_frame
// Input register and per-port framing state: open flag, fill count and
// payload store. Hands complete packets to the emitter.
// ----------------------------------------------------------------------------
module dpr_frame #(
  parameter int PACKET_BYTES = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  dpr_in_if.sink                                 in_i,
  input  logic                                   free_i,
  output dpr_pkg::dpr_load_t                     load_o,
  output logic [PACKET_BYTES-2:0][7:0]           payload_o
);
  import dpr_pkg::*;

  localparam int PL = PACKET_BYTES - 1;
  localparam int CW = $clog2(PACKET_BYTES);
  localparam int IW = (PL > 1) ? $clog2(PL) : 1;
  localparam logic [CW-1:0] PL_C = CW'(PL);

  logic                     s_valid_q;
  logic                     s_port_q;
  logic [7:0]               s_byte_q;
  logic [1:0]               open_q;
  logic [1:0][CW-1:0]       fill_q;
  logic [1:0][PL-1:0][7:0]  store_q;

  logic          cur_open;
  logic [CW-1:0] cur_fill;
  logic          is_tab, is_nl, is_cr;
  logic          complete;
  logic          advance;
  logic          append;

  assign cur_open = open_q[s_port_q];
  assign cur_fill = fill_q[s_port_q];
  assign is_tab   = (s_byte_q == CH_TAB);
  assign is_nl    = (s_byte_q == CH_NL);
  assign is_cr    = (s_byte_q == CH_CR);

  // A newline on a full packet must wait until the emitter can take it.
  assign complete = s_valid_q && cur_open && is_nl && (cur_fill == PL_C);
  assign advance  = s_valid_q && (!complete || free_i);
  assign append   = advance && cur_open && !is_nl && !is_tab && !is_cr && (cur_fill < PL_C);

  assign in_i.ready     = !s_valid_q || advance;
  assign load_o.load    = complete && free_i;
  assign load_o.port    = s_port_q;
  assign payload_o      = store_q[s_port_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      s_port_q  <= 1'b0;
      s_byte_q  <= '0;
      open_q    <= '0;
      fill_q    <= '0;
    end else begin
      if (in_i.ready) begin
        s_valid_q <= in_i.valid;
        s_port_q  <= in_i.source_port;
        s_byte_q  <= in_i.in_byte;
      end
      if (advance) begin
        if (!cur_open) begin
          if (is_tab) begin
            open_q[s_port_q] <= 1'b1;
          end
        end else if (is_nl) begin
          open_q[s_port_q] <= 1'b0;
          fill_q[s_port_q] <= '0;
        end else if (append) begin
          fill_q[s_port_q] <= cur_fill + CW'(1);
        end
      end
    end
  end

  // Payload bytes carry no reset.
  always_ff @(posedge clk_i) begin
    if (append) begin
      store_q[s_port_q][cur_fill[IW-1:0]] <= s_byte_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= PL_C) && (fill_q[1] <= PL_C))
    else $error("fill count beyond payload length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q[0] || fill_q[0] == '0) && (open_q[1] || fill_q[1] == '0))
    else $error("closed port holds payload bytes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o.load |=> !open_q[$past(s_port_q)] && fill_q[$past(s_port_q)] == '0)
    else $error("packet handed over without closing its port");

endmodule

>>> sv/dpr_emit.sv
// ----------------------------------------------------------------------------
// dpr_emit
// Packet emitter: holds a copy of one complete packet and sends tab,
// payload bytes and newline as output items.
// ----------------------------------------------------------------------------
module dpr_emit #(
  parameter int PACKET_BYTES = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dpr_pkg::dpr_load_t            load_i,
  input  logic [PACKET_BYTES-2:0][7:0]  payload_i,
  output logic                          free_o,
  dpr_out_if.source                     out_o
);
  import dpr_pkg::*;

  localparam int PL = PACKET_BYTES - 1;
  localparam int XW = $clog2(PACKET_BYTES + 1);
  localparam logic [XW-1:0] LAST_IDX = XW'(PACKET_BYTES);

  logic                busy_q;
  logic [XW-1:0]       idx_q;
  logic                port_q;
  logic [PL-1:0][7:0]  buf_q;

  logic fire;
  logic is_last;

  assign is_last = (idx_q == LAST_IDX);
  assign fire    = busy_q && out_o.ready;
  assign free_o  = !busy_q || (fire && is_last);

  assign out_o.valid     = busy_q;
  assign out_o.out_port  = port_q;
  assign out_o.last_byte = is_last;
  always_comb begin
    if (idx_q == '0) begin
      out_o.out_byte = CH_TAB;
    end else if (is_last) begin
      out_o.out_byte = CH_NL;
    end else begin
      out_o.out_byte = buf_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      port_q <= 1'b0;
    end else if (load_i.load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      port_q <= load_i.port;
    end else if (fire) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + XW'(1);
      end
    end
  end

  // Payload shifts towards entry zero once each payload byte is taken.
  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      buf_q <= payload_i;
    end else if (fire && (idx_q != '0)) begin
      for (int i = 0; i < PL - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= LAST_IDX)
    else $error("emitter index out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.load |-> free_o)
    else $error("packet loaded while emitter busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_last && !load_i.load) |=> busy_q && idx_q == $past(idx_q) + XW'(1))
    else $error("emitter lost its place in a packet");

endmodule

>>> verif/delimited_packet_relay_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_packet_relay_test
// Self-checking bench for the two-port packet relay. Bytes are sent on both
// ports with random gaps, a behavioural deframer predicts the relayed
// items, and every item taken from the output is checked field by field.
// ----------------------------------------------------------------------------
module delimited_packet_relay_test;
  import dpr_pkg::*;

  localparam int PACKET_BYTES = 14;
  localparam int PAYLOAD_LEN  = PACKET_BYTES - 1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTED  = 20;

  // One relayed item as it should appear on the output channel.
  typedef struct packed {
    logic       port;
    logic [7:0] data;
    logic       last;
  } relay_item_t;

  logic clk;
  logic rst_n;

  dpr_in_if  in_ch ();
  dpr_out_if out_ch ();

  delimited_packet_relay #(
    .PACKET_BYTES(PACKET_BYTES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Items the relay still owes us, oldest first.
  relay_item_t relayed_items_due[$];

  // Per-port framing state of the behavioural deframer.
  bit         port_open[2];
  int         port_fill[2];
  logic [7:0] port_payload[2][PAYLOAD_LEN];

  // When set, neither the sender nor the receiver leaves any gap.
  bit no_idle;

  int cycle_count;
  int mismatches;
  int bytes_sent;
  int bytes_effective;
  int items_checked;
  int packets_seen;

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The watchdog: a correct run finishes long before this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d items still due", cycle_count,
               relayed_items_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A payload byte that is none of the framing characters.
  function automatic logic [7:0] random_payload();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_TAB || b == CH_NL || b == CH_CR);
    return b;
  endfunction

  // Deframes one received byte, queuing the relayed items it causes. The
  // return value tells whether the byte changed any state at all, so that
  // bytes the relay simply ignores do not count as useful stimulus.
  function automatic bit deframe_byte(input logic port, input logic [7:0] b);
    relay_item_t it;
    if (!port_open[port]) begin
      if (b == CH_TAB) begin
        port_open[port] = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (b == CH_NL) begin
      // Only a packet holding its full payload is relayed; anything shorter
      // is dropped without trace.
      if (port_fill[port] == PAYLOAD_LEN) begin
        it = '{port: port, data: CH_TAB, last: 1'b0};
        relayed_items_due.push_back(it);
        for (int k = 0; k < PAYLOAD_LEN; k++) begin
          it = '{port: port, data: port_payload[port][k], last: 1'b0};
          relayed_items_due.push_back(it);
        end
        it = '{port: port, data: CH_NL, last: 1'b1};
        relayed_items_due.push_back(it);
      end
      port_fill[port] = 0;
      port_open[port] = 1'b0;
      return 1'b1;
    end
    // Tabs and carriage returns inside an open packet are skipped, and so
    // is every byte once the payload is full.
    if (b == CH_TAB || b == CH_CR) return 1'b0;
    if (port_fill[port] < PAYLOAD_LEN) begin
      port_payload[port][port_fill[port]] = b;
      port_fill[port]++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Offers one byte after a random gap and returns at the edge where it is
  // taken. Valid stays high on return so that back-to-back items need no
  // second assignment in the same step.
  task automatic send_byte(input logic port, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.source_port <= port;
    in_ch.in_byte     <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (deframe_byte(port, b)) bytes_effective++;
  endtask

  // A tab, n_payload bytes and a newline on one port. With noisy set, stray
  // bytes on either port are slipped in between now and then.
  task automatic send_packet(input logic port, input int n_payload, input bit noisy);
    int k;
    send_byte(port, CH_TAB);
    for (k = 0; k < n_payload; k++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      send_byte(port, random_payload());
    end
    send_byte(port, CH_NL);
  endtask

  // The receiver stalls at random; during quiet phases it never stalls.
  initial begin : sink_pacing
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Every item taken from the output is matched against the oldest one due.
  always @(posedge clk) begin
    relay_item_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      items_checked++;
      if (relayed_items_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item port %0d byte %02h last %0d",
                                  out_ch.out_port, out_ch.out_byte, out_ch.last_byte));
      end else begin
        due = relayed_items_due.pop_front();
        if (out_ch.out_port !== due.port)
          report_mismatch($sformatf("out_port %0d, expected %0d", out_ch.out_port, due.port));
        if (out_ch.out_byte !== due.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_ch.out_byte, due.data));
        if (out_ch.last_byte !== due.last)
          report_mismatch($sformatf("last_byte %0d, expected %0d", out_ch.last_byte, due.last));
        if (due.last) packets_seen++;
      end
    end
  end

  // Bytes on a closed port, including a lone newline, must leave no trace.
  task automatic test_closed_port_noise();
    send_byte(1'b0, CH_NL);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, CH_CR);
  endtask

  // A packet that closes with too few payload bytes is dropped.
  task automatic test_short_packet();
    send_byte(1'b1, CH_TAB);
    send_byte(1'b0 ^ 1'b1, 8'h00);
    send_byte(1'b1, CH_NL);
  endtask

  // A full packet with extreme payload values, a repeated tab and a carriage
  // return inside it, and one byte too many before the newline.
  task automatic test_full_packet_with_extras();
    logic [7:0] payload [PAYLOAD_LEN];
    int k;
    payload = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA,
                8'h0B, 8'h0C, 8'h0E, 8'h08, 8'h41};
    send_byte(1'b0, CH_TAB);
    send_byte(1'b0, CH_TAB);
    send_byte(1'b0, CH_CR);
    for (k = 0; k < PAYLOAD_LEN; k++) send_byte(1'b0, payload[k]);
    send_byte(1'b0, 8'h5A);
    send_byte(1'b0, CH_NL);
  endtask

  // Both ports build a packet at once, byte by byte in turn, and close them
  // on consecutive items, so the second packet completes while the first is
  // still being relayed and the input has to be held back.
  task automatic test_interleaved_ports();
    int k;
    no_idle = 1'b1;
    send_byte(1'b0, CH_TAB);
    send_byte(1'b1, CH_TAB);
    for (k = 0; k < PAYLOAD_LEN; k++) begin
      send_byte(1'b0, random_payload());
      send_byte(1'b1, random_payload());
    end
    send_byte(1'b1, CH_NL);
    send_byte(1'b0, CH_NL);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed packets with random content, the rest short packets,
  // overlong packets and loose bytes. Runs until enough bytes have had an
  // effect on the framing state.
  task automatic test_random_traffic(input int target, input bit with_idle);
    int start;
    int roll;
    int k;
    logic port;
    no_idle = !with_idle;
    start = bytes_effective;
    while (bytes_effective - start < target) begin
      roll = $urandom_range(0, 99);
      port = 1'($urandom_range(0, 1));
      if (roll < 70) begin
        send_packet(port, PAYLOAD_LEN, roll < 15);
      end else if (roll < 80) begin
        send_packet(port, $urandom_range(0, PAYLOAD_LEN - 1), 1'b0);
      end else if (roll < 88) begin
        send_packet(port, PAYLOAD_LEN + $urandom_range(1, 4), 1'b0);
      end else begin
        for (k = $urandom_range(1, 4); k > 0; k--)
          send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : main_sequence
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.source_port = 1'b0;
    in_ch.in_byte     = 8'h00;
    no_idle           = 1'b0;
    for (int p = 0; p < 2; p++) begin
      port_open[p] = 1'b0;
      port_fill[p] = 0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_closed_port_noise();
    test_short_packet();
    test_full_packet_with_extras();
    test_interleaved_ports();
    test_random_traffic(120, 1'b1);
    test_random_traffic(40, 1'b0);

    in_ch.valid <= 1'b0;
    // Drain what is owed, then keep clocking so that the relay can show any
    // item it should not send.
    while (relayed_items_due.size() != 0) @(posedge clk);
    repeat (PACKET_BYTES + 10) @(posedge clk);

    $display("tb: sent %0d bytes on two ports, %0d of them altering the framing state",
             bytes_sent, bytes_effective);
    $display("tb: checked %0d relayed items in %0d complete packets, %0d mismatches",
             items_checked, packets_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dpr_pkg.sv
sv/dpr_if.sv
sv/dpr_frame.sv
sv/dpr_emit.sv
sv/delimited_packet_relay.sv
verif/delimited_packet_relay_test.sv
